// File: hdl/hrhp_pkg.sv
// Shared types, codes and constants for the HTTP request head parser.
`timescale 1ns / 1ps
`default_nettype none
package hrhp_pkg;

    localparam int FIFO_DEPTH_DEF = 4;

    localparam int DATA_W  = 8;
    localparam int TDATA_W = 16;
    localparam int KIND_W  = 2;
    localparam int ST_W    = 2;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_METHOD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PATH   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd2;

    // status codes
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD       = 2'd1;
    localparam logic [ST_W-1:0] ST_VERSION   = 2'd2;
    localparam logic [ST_W-1:0] ST_MALFORMED = 2'd3;

    // characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic [3:0] VCOUNT_MIN = 4'd9;
    localparam int         PREFIX_LAST = 4;

    typedef enum logic [3:0] {
        PH_SKIP      = 4'd0,
        PH_METHOD    = 4'd1,
        PH_GAP1      = 4'd2,
        PH_PATH      = 4'd3,
        PH_GAP2      = 4'd4,
        PH_PREFIX    = 4'd5,
        PH_MAJ_FIRST = 4'd6,
        PH_MAJ       = 4'd7,
        PH_MIN_FIRST = 4'd8,
        PH_MIN       = 4'd9,
        PH_TAIL      = 4'd10,
        PH_DONE      = 4'd11,
        PH_SINK      = 4'd12
    } phase_t;

    // one queued command: an optional text item, then an optional status item
    typedef struct packed {
        logic              has_text;
        logic [KIND_W-1:0] text_kind;
        logic [DATA_W-1:0] text_byte;
        logic              has_status;
        logic [ST_W-1:0]   status;
        logic              minor_is_one;
    } cmd_t;

    // "HTTP/" by position
    function automatic logic [7:0] prefix_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h48;
            3'd1:    c = 8'h54;
            3'd2:    c = 8'h54;
            3'd3:    c = 8'h50;
            3'd4:    c = 8'h2F;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // decimal digit append, saturating at 3
    function automatic logic [1:0] sat_digit(input logic [1:0] m, input logic [3:0] d);
        logic [1:0] v;
        if (m != 2'd0 || d > 4'd3)
            v = 2'd3;
        else
            v = d[1:0];
        return v;
    endfunction

endpackage
`default_nettype wire

// File: hdl/http_request_head_parser_core.sv
// Top level of the HTTP request head parser: front end, command queue, output stage.
// Throughput: one head byte per cycle until the command queue fills; a last byte that
//   is also a method or path byte yields two output transfers (text, then status).
// Path: a byte's command is written into the queue when the byte transfers, then loaded
//   into the output register once that register is empty or finishing its command.
// Reset: rst_n asynchronous, active low; parser returns to line-break skip, queue empties.
`timescale 1ns / 1ps
`default_nettype none
module http_request_head_parser_core
#(
    parameter int FIFO_DEPTH = hrhp_pkg::FIFO_DEPTH_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [hrhp_pkg::DATA_W-1:0]  s_tdata,   // [7:0] data_byte
    input  wire logic                         s_tlast,   // end_of_head
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [hrhp_pkg::TDATA_W-1:0]      m_tdata,   // [7:0] text_byte, [9:8] head_status,
                                                         // [10] minor_is_one, [15:11] zero
    output logic [hrhp_pkg::KIND_W-1:0]       m_tuser,   // [1:0] item_kind
    output logic                              m_tlast    // run_last
);

    hrhp_pkg::cmd_t push_cmd;
    hrhp_pkg::cmd_t pop_cmd;
    logic           cmd_push;
    logic           cmd_pop;
    logic           fifo_full;
    logic           fifo_empty;

    hrhp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .fifo_full (fifo_full),
        .cmd_push  (cmd_push),
        .cmd       (push_cmd)
    );

    hrhp_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (push_cmd),
        .pop       (cmd_pop),
        .pop_data  (pop_cmd),
        .full      (fifo_full),
        .empty     (fifo_empty)
    );

    hrhp_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_data  (pop_cmd),
        .fifo_empty (fifo_empty),
        .cmd_pop    (cmd_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !fifo_full)
        else $error("command pushed into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !fifo_empty)
        else $error("command popped from empty queue");

    a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser == hrhp_pkg::KIND_STATUS)))
        else $error("tlast does not match status item");

    a_last_byte_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |-> (cmd_push && push_cmd.has_status))
        else $error("last byte did not queue a status");
`endif

endmodule
`default_nettype wire

// File: hdl/hrhp_front.sv
// Front end: accepts head bytes, runs the request line and header checks, emits commands.
`timescale 1ns / 1ps
`default_nettype none
module hrhp_front
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [hrhp_pkg::DATA_W-1:0] s_tdata,
    input  wire logic                        s_tlast,
    input  wire logic                        fifo_full,
    output logic                             cmd_push,
    output hrhp_pkg::cmd_t                   cmd
);

    localparam logic [1:0] HL_START    = 2'd0;
    localparam logic [1:0] HL_HEADER   = 2'd1;
    localparam logic [1:0] HL_CONT     = 2'd2;
    localparam logic [1:0] HL_AFTER_LF = 2'd3;

    hrhp_pkg::phase_t phase_reg, phase_step, phase_next, phase_w;
    logic [2:0] prefix_reg, prefix_step, prefix_next;
    logic [1:0] major_reg, major_step, major_next;
    logic [1:0] minor_reg, minor_step, minor_next;
    logic [3:0] vcount_reg, vcount_step, vcount_next;
    logic [1:0] ferr_reg, ferr_step, ferr_next;
    logic       seen_reg, seen_step, seen_next;
    logic [1:0] hls_reg, hls_step, hls_next;
    logic       colon_reg, colon_step, colon_next;
    logic       hfail_reg, hfail_step, hfail_next;
    logic       first_reg, first_next;

    logic       accept;
    logic       active;
    logic       sp;
    logic       dig;
    logic [3:0] dval;
    logic       ver_bad_cur;
    logic       has_text;
    logic [1:0] final_st;

    assign accept      = s_tvalid && s_tready;
    assign s_tready    = !fifo_full;
    assign sp          = (s_tdata == hrhp_pkg::CH_SPACE) || (s_tdata == hrhp_pkg::CH_TAB);
    assign dig         = (s_tdata >= hrhp_pkg::CH_ZERO) && (s_tdata <= hrhp_pkg::CH_NINE);
    assign dval        = 4'(s_tdata - hrhp_pkg::CH_ZERO);
    assign ver_bad_cur = (major_reg != 2'd1) || (minor_reg > 2'd1);
    assign phase_w     = (phase_reg == hrhp_pkg::PH_SKIP) ? hrhp_pkg::PH_METHOD : phase_reg;
    assign active      = !(first_reg && s_tdata == hrhp_pkg::CH_NUL)
                         && !(phase_reg == hrhp_pkg::PH_SINK
                              && ferr_reg == hrhp_pkg::ST_MALFORMED)
                         && !(phase_reg == hrhp_pkg::PH_SKIP
                              && (s_tdata == hrhp_pkg::CH_CR || s_tdata == hrhp_pkg::CH_LF));

    // next state for one byte
    always_comb
    begin
        hrhp_pkg::phase_t vph;
        logic [2:0]       vpos;
        phase_step  = phase_reg;
        prefix_step = prefix_reg;
        major_step  = major_reg;
        minor_step  = minor_reg;
        vcount_step = vcount_reg;
        ferr_step   = ferr_reg;
        seen_step   = seen_reg;
        hls_step    = hls_reg;
        colon_step  = colon_reg;
        hfail_step  = hfail_reg;
        vph         = phase_w;
        vpos        = prefix_reg;
        if (first_reg && s_tdata == hrhp_pkg::CH_NUL)
        begin
            ferr_step  = hrhp_pkg::ST_MALFORMED;
            phase_step = hrhp_pkg::PH_SINK;
        end
        else if (active)
        begin
            phase_step = phase_w;
            // header lines
            if (s_tdata == hrhp_pkg::CH_NUL)
                hfail_step = 1'b1;
            if (!seen_reg)
            begin
                if (s_tdata == hrhp_pkg::CH_LF)
                begin
                    seen_step = 1'b1;
                    hls_step  = HL_START;
                end
            end
            else
            begin
                case (hls_reg)
                    HL_HEADER:
                    begin
                        if (s_tdata == hrhp_pkg::CH_COLON)
                            colon_step = 1'b1;
                        if (s_tdata == hrhp_pkg::CH_LF)
                        begin
                            if (!colon_reg)
                                hfail_step = 1'b1;
                            hls_step = HL_AFTER_LF;
                        end
                    end
                    HL_CONT:
                    begin
                        if (s_tdata == hrhp_pkg::CH_LF)
                            hls_step = HL_AFTER_LF;
                    end
                    default:
                    begin
                        if (hls_reg == HL_AFTER_LF && sp)
                            hls_step = HL_CONT;
                        else if (s_tdata == hrhp_pkg::CH_LF)
                        begin
                            hfail_step = 1'b1;
                            hls_step   = HL_AFTER_LF;
                        end
                        else
                        begin
                            colon_step = (s_tdata == hrhp_pkg::CH_COLON);
                            hls_step   = HL_HEADER;
                        end
                    end
                endcase
            end
            if (vcount_reg != 4'd0 && vcount_reg < hrhp_pkg::VCOUNT_MIN)
                vcount_step = vcount_reg + 4'd1;
            // request line
            if (phase_w == hrhp_pkg::PH_GAP2 && !sp)
            begin
                prefix_step = 3'd0;
                vcount_step = 4'd1;
                vph         = hrhp_pkg::PH_PREFIX;
                vpos        = 3'd0;
                phase_step  = hrhp_pkg::PH_PREFIX;
            end
            unique case (vph)
                hrhp_pkg::PH_METHOD:
                    if (sp)
                        phase_step = hrhp_pkg::PH_GAP1;
                hrhp_pkg::PH_GAP1:
                    if (!sp)
                        phase_step = hrhp_pkg::PH_PATH;
                hrhp_pkg::PH_PATH:
                    if (sp)
                        phase_step = hrhp_pkg::PH_GAP2;
                hrhp_pkg::PH_PREFIX:
                begin
                    if (vpos > 3'(hrhp_pkg::PREFIX_LAST)
                        || s_tdata != hrhp_pkg::prefix_char(vpos))
                    begin
                        ferr_step  = hrhp_pkg::ST_BAD;
                        phase_step = hrhp_pkg::PH_SINK;
                    end
                    else if (vpos == 3'(hrhp_pkg::PREFIX_LAST))
                        phase_step = hrhp_pkg::PH_MAJ_FIRST;
                    else
                        prefix_step = vpos + 3'd1;
                end
                hrhp_pkg::PH_MAJ_FIRST:
                begin
                    if (dig)
                    begin
                        major_step = hrhp_pkg::sat_digit(2'd0, dval);
                        phase_step = hrhp_pkg::PH_MAJ;
                    end
                    else
                    begin
                        ferr_step  = hrhp_pkg::ST_BAD;
                        phase_step = hrhp_pkg::PH_SINK;
                    end
                end
                hrhp_pkg::PH_MAJ:
                begin
                    if (dig)
                        major_step = hrhp_pkg::sat_digit(major_reg, dval);
                    else if (s_tdata == hrhp_pkg::CH_DOT)
                        phase_step = hrhp_pkg::PH_MIN_FIRST;
                    else
                    begin
                        ferr_step  = hrhp_pkg::ST_BAD;
                        phase_step = hrhp_pkg::PH_SINK;
                    end
                end
                hrhp_pkg::PH_MIN_FIRST:
                begin
                    if (dig)
                    begin
                        minor_step = hrhp_pkg::sat_digit(2'd0, dval);
                        phase_step = hrhp_pkg::PH_MIN;
                    end
                    else
                    begin
                        ferr_step  = hrhp_pkg::ST_BAD;
                        phase_step = hrhp_pkg::PH_SINK;
                    end
                end
                hrhp_pkg::PH_MIN, hrhp_pkg::PH_TAIL:
                begin
                    if (vph == hrhp_pkg::PH_MIN && dig)
                        minor_step = hrhp_pkg::sat_digit(minor_reg, dval);
                    else if (vph == hrhp_pkg::PH_MIN && ver_bad_cur)
                    begin
                        ferr_step  = hrhp_pkg::ST_VERSION;
                        phase_step = hrhp_pkg::PH_SINK;
                    end
                    else if (s_tdata == hrhp_pkg::CH_CR || s_tdata == hrhp_pkg::CH_SPACE)
                        phase_step = hrhp_pkg::PH_TAIL;
                    else if (s_tdata == hrhp_pkg::CH_LF)
                        phase_step = hrhp_pkg::PH_DONE;
                    else
                    begin
                        ferr_step  = hrhp_pkg::ST_BAD;
                        phase_step = hrhp_pkg::PH_SINK;
                    end
                end
                default:
                    ;
            endcase
        end
    end

    // commit or return to reset values after the last byte
    always_comb
    begin
        if (s_tlast)
        begin
            phase_next  = hrhp_pkg::PH_SKIP;
            prefix_next = 3'd0;
            major_next  = 2'd0;
            minor_next  = 2'd0;
            vcount_next = 4'd0;
            ferr_next   = hrhp_pkg::ST_OK;
            seen_next   = 1'b0;
            hls_next    = HL_START;
            colon_next  = 1'b0;
            hfail_next  = 1'b0;
            first_next  = 1'b1;
        end
        else
        begin
            phase_next  = phase_step;
            prefix_next = prefix_step;
            major_next  = major_step;
            minor_next  = minor_step;
            vcount_next = vcount_step;
            ferr_next   = ferr_step;
            seen_next   = seen_step;
            hls_next    = hls_step;
            colon_next  = colon_step;
            hfail_next  = hfail_step;
            first_next  = 1'b0;
        end
    end

    // outputs
    always_comb
    begin
        has_text = active
                   && (((phase_w == hrhp_pkg::PH_METHOD || phase_w == hrhp_pkg::PH_PATH)
                        && !sp)
                       || (phase_w == hrhp_pkg::PH_GAP1 && !sp));
        if (ferr_step == hrhp_pkg::ST_MALFORMED)
            final_st = hrhp_pkg::ST_MALFORMED;
        else if (phase_step == hrhp_pkg::PH_SKIP || phase_step == hrhp_pkg::PH_METHOD
                 || phase_step == hrhp_pkg::PH_GAP1 || phase_step == hrhp_pkg::PH_PATH
                 || phase_step == hrhp_pkg::PH_GAP2)
            final_st = hrhp_pkg::ST_BAD;
        else if (vcount_step < hrhp_pkg::VCOUNT_MIN)
            final_st = hrhp_pkg::ST_BAD;
        else if (ferr_step != hrhp_pkg::ST_OK)
            final_st = ferr_step;
        else if (phase_step == hrhp_pkg::PH_MIN
                 && (major_step != 2'd1 || minor_step > 2'd1))
            final_st = hrhp_pkg::ST_VERSION;
        else if (phase_step != hrhp_pkg::PH_DONE)
            final_st = hrhp_pkg::ST_BAD;
        else if (hfail_step || !seen_step || hls_step == HL_HEADER || hls_step == HL_CONT)
            final_st = hrhp_pkg::ST_BAD;
        else
            final_st = hrhp_pkg::ST_OK;

        cmd.has_text     = has_text;
        cmd.text_kind    = (phase_w == hrhp_pkg::PH_METHOD) ? hrhp_pkg::KIND_METHOD
                                                            : hrhp_pkg::KIND_PATH;
        cmd.text_byte    = s_tdata;
        cmd.has_status   = s_tlast;
        cmd.status       = final_st;
        cmd.minor_is_one = (final_st == hrhp_pkg::ST_OK) && (minor_step == 2'd1);
        cmd_push         = accept && (has_text || s_tlast);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= hrhp_pkg::PH_SKIP;
            prefix_reg <= 3'd0;
            major_reg  <= 2'd0;
            minor_reg  <= 2'd0;
            vcount_reg <= 4'd0;
            ferr_reg   <= hrhp_pkg::ST_OK;
            seen_reg   <= 1'b0;
            hls_reg    <= HL_START;
            colon_reg  <= 1'b0;
            hfail_reg  <= 1'b0;
            first_reg  <= 1'b1;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            prefix_reg <= prefix_next;
            major_reg  <= major_next;
            minor_reg  <= minor_next;
            vcount_reg <= vcount_next;
            ferr_reg   <= ferr_next;
            seen_reg   <= seen_next;
            hls_reg    <= hls_next;
            colon_reg  <= colon_next;
            hfail_reg  <= hfail_next;
            first_reg  <= first_next;
        end
    end

endmodule
`default_nettype wire

// File: hdl/hrhp_fifo.sv
// Command queue between the front end and the output stage.
`timescale 1ns / 1ps
`default_nettype none
module hrhp_fifo
#(
    parameter int DEPTH = hrhp_pkg::FIFO_DEPTH_DEF
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire hrhp_pkg::cmd_t push_data,
    input  wire logic           pop,
    output hrhp_pkg::cmd_t      pop_data,
    output logic                full,
    output logic                empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hrhp_pkg::cmd_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

// File: hdl/hrhp_back.sv
// Output stage: unpacks queued commands into result transfers.
`timescale 1ns / 1ps
`default_nettype none
module hrhp_back
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire hrhp_pkg::cmd_t               fifo_data,
    input  wire logic                         fifo_empty,
    output logic                              cmd_pop,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [hrhp_pkg::TDATA_W-1:0]      m_tdata,
    output logic [hrhp_pkg::KIND_W-1:0]       m_tuser,
    output logic                              m_tlast
);

    hrhp_pkg::cmd_t cur_reg, cur_next;
    logic           valid_reg, valid_next;
    logic           text_done_reg, text_done_next;
    logic           emit_text;
    logic           xfer;
    logic           finish;
    logic           load;

    assign emit_text = cur_reg.has_text && !text_done_reg;
    assign xfer      = valid_reg && m_tready;
    assign finish    = xfer && !(emit_text && cur_reg.has_status);
    assign load      = !valid_reg || finish;
    assign cmd_pop   = load && !fifo_empty;

    always_comb
    begin
        cur_next       = cur_reg;
        valid_next     = valid_reg;
        text_done_next = text_done_reg;
        if (load)
        begin
            cur_next       = fifo_data;
            valid_next     = !fifo_empty;
            text_done_next = 1'b0;
        end
        else if (xfer)
            text_done_next = 1'b1;
    end

    always_comb
    begin
        m_tvalid = valid_reg;
        if (emit_text)
        begin
            m_tuser = cur_reg.text_kind;
            m_tdata = {{(hrhp_pkg::TDATA_W - hrhp_pkg::DATA_W){1'b0}}, cur_reg.text_byte};
            m_tlast = 1'b0;
        end
        else
        begin
            m_tuser = hrhp_pkg::KIND_STATUS;
            m_tdata = {{(hrhp_pkg::TDATA_W - hrhp_pkg::DATA_W - hrhp_pkg::ST_W - 1){1'b0}},
                       cur_reg.minor_is_one, cur_reg.status, {hrhp_pkg::DATA_W{1'b0}}};
            m_tlast = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            text_done_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            text_done_reg <= text_done_next;
        end
    end

endmodule
`default_nettype wire
